### rtl/core/psi_pkg.sv
// Shared types and constants for the profile setpoint interpolator.
`timescale 1ns / 1ps

package psi_pkg;

  // Field widths of the request and result items.
  localparam int TimeW  = 16;
  localparam int TempW  = 10;
  localparam int SlotW  = 4;
  localparam int CountW = 5;

  // Table depth default and point count after reset.
  localparam int MaxPointsDefault = 16;
  localparam logic [CountW-1:0] PointCountReset = CountW'(10);

  // Divider geometry: the magnitude of the product holds at most this many bits.
  localparam int QuoW     = TimeW + TempW;
  localparam int RemW     = TimeW + 1;
  localparam int StepW    = $clog2(QuoW);
  localparam int DivSteps = QuoW;

  // Highest temperature that a result can carry.
  localparam int TempMax = (1 << TempW) - 1;

  // Request kinds.
  typedef enum logic [0:0] {
    ACT_WRITE = 1'b0,
    ACT_QUERY = 1'b1
  } psi_action_e;

  // One request item.
  typedef struct packed {
    psi_action_e        action;
    logic [SlotW-1:0]   point_index;
    logic [TimeW-1:0]   point_time;
    logic [TempW-1:0]   point_temperature;
    logic [TimeW-1:0]   query_time;
  } psi_in_t;

  // One result item.
  typedef struct packed {
    logic [TempW-1:0] target_temperature;
    logic             in_range;
  } psi_out_t;

  // One stored breakpoint.
  typedef struct packed {
    logic [TimeW-1:0] pt_time;
    logic [TempW-1:0] pt_temp;
  } psi_point_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MUL,
    ST_DIV,
    ST_ADJ,
    ST_FIN
  } psi_state_e;

endpackage

### rtl/core/profile_setpoint_interpolator.sv
// Top level of the profile setpoint interpolator: breakpoint table, scan and serial divider.
`timescale 1ns / 1ps

// A write request stores one breakpoint and leaves the block idle and ready; it
// gives no result. A query request scans the breakpoints in use (n = point_count,
// clamped to 2..MAX_POINTS) one table entry per cycle through the registered read
// port of the breakpoint memory, and the first entry that matches or brackets the
// query time decides. An exact match or a miss goes from the scan straight to the
// finish state. An interpolation passes through a multiply state, 26
// restoring-division steps of the shared subtractor and a state that applies the
// sign and offset.
// A finished result waits in the output register; the block takes the next request
// while it waits, and a following query stalls only at its very end if the earlier
// result is still not taken. The breakpoint memory has no reset, so every point in
// use must be written before it is queried.
module profile_setpoint_interpolator #(
  parameter int MAX_POINTS = psi_pkg::MaxPointsDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [psi_pkg::CountW-1:0]  cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  psi_pkg::psi_in_t            in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output psi_pkg::psi_out_t           out_data_o
);

  localparam int IdxW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int NumW = (psi_pkg::CountW > $clog2(MAX_POINTS + 1)) ?
                        psi_pkg::CountW : $clog2(MAX_POINTS + 1);
  localparam int TW   = psi_pkg::TimeW;
  localparam int VW   = psi_pkg::TempW;
  localparam int QW   = psi_pkg::QuoW;
  localparam int RW   = psi_pkg::RemW;
  localparam int SW   = psi_pkg::StepW;

  psi_pkg::psi_state_e state_q, state_d;

  // Configuration and control registers.
  logic [psi_pkg::CountW-1:0] point_count_q;
  logic [IdxW-1:0]            idx_q;
  logic [SW-1:0]              step_q;
  logic                       out_valid_q;

  // Datapath registers.
  psi_pkg::psi_point_t        rd_q;
  logic [TW-1:0]              query_q;
  logic [TW-1:0]              prev_time_q;
  logic [VW-1:0]              prev_temp_q;
  logic [TW-1:0]              dt_q;
  logic [TW-1:0]              den_q;
  logic signed [VW:0]         dv_q;
  logic [VW-1:0]              v0_q;
  logic [QW-1:0]              quo_q;
  logic [RW-1:0]              rem_q;
  logic                       neg_q;
  logic [VW-1:0]              res_temp_q;
  logic                       res_found_q;
  psi_pkg::psi_out_t          out_data_q;

  // Breakpoint memory.
  psi_pkg::psi_point_t mem_q [MAX_POINTS];

  logic                 in_accept;
  logic                 mem_we;
  logic [IdxW-1:0]      wr_addr;
  logic [IdxW-1:0]      rd_addr;
  logic                 slot_ok;
  logic [NumW-1:0]      count_ext;
  logic [NumW-1:0]      num_used;
  logic [IdxW-1:0]      last_idx;
  logic                 hit_between;
  logic                 hit_equal;
  logic                 scan_last;
  logic                 out_free;
  logic signed [2*TW+1:0] prod_wide;
  logic signed [TW+VW+1:0] prod;
  logic [TW+VW+1:0]     prod_mag;
  logic [RW-1:0]        rem_shift;
  logic [RW:0]          rem_diff;
  logic                 div_ge;
  logic signed [VW+2:0] quo_signed;
  logic signed [VW+2:0] lerp_sum;
  logic [VW-1:0]        lerp_temp;

  assign in_accept = in_valid_i && in_ready_o;
  assign out_free  = !out_valid_q || out_ready_i;

  // Points in use, clamped to the table.
  assign count_ext = NumW'(point_count_q);
  always_comb begin
    if (count_ext < NumW'(2)) begin
      num_used = NumW'(2);
    end else if (count_ext > NumW'(MAX_POINTS)) begin
      num_used = NumW'(MAX_POINTS);
    end else begin
      num_used = count_ext;
    end
  end
  assign last_idx = IdxW'(num_used - NumW'(1));

  // Scan decisions on the entry just read and the one before it.
  assign hit_between = (idx_q != '0) && (prev_time_q < query_q) && (query_q < rd_q.pt_time);
  assign hit_equal   = (rd_q.pt_time == query_q);
  assign scan_last   = (idx_q == last_idx);

  // Write slot check and addresses.
  assign slot_ok = (32'(in_data_i.point_index) < MAX_POINTS);
  assign wr_addr = IdxW'(in_data_i.point_index);

  // Multiplier: offset into the segment times the temperature step.
  assign prod_wide = $signed({1'b0, dt_q}) * $signed({{(TW - VW){dv_q[VW]}}, dv_q});
  assign prod      = prod_wide[TW+VW+1:0];
  assign prod_mag  = prod[TW+VW+1] ? (TW+VW+2)'(-prod) : prod;

  // Restoring divider step on the shared subtractor.
  assign rem_shift = {rem_q[RW-2:0], quo_q[QW-1]};
  assign rem_diff  = {1'b0, rem_shift} - {2'b00, den_q};
  assign div_ge    = !rem_diff[RW];

  // Signed quotient plus the segment start, kept within the temperature range.
  assign quo_signed = $signed({2'b00, quo_q[VW:0]});
  assign lerp_sum   = $signed({3'b000, v0_q}) + (neg_q ? -quo_signed : quo_signed);
  always_comb begin
    if (lerp_sum < 0) begin
      lerp_temp = '0;
    end else if (lerp_sum > (VW+3)'(psi_pkg::TempMax)) begin
      lerp_temp = VW'(psi_pkg::TempMax);
    end else begin
      lerp_temp = lerp_sum[VW-1:0];
    end
  end

  // Next-state logic of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      psi_pkg::ST_IDLE: begin
        if (in_accept && (in_data_i.action == psi_pkg::ACT_QUERY)) begin
          state_d = psi_pkg::ST_SCAN;
        end
      end
      psi_pkg::ST_SCAN: begin
        if (hit_between) begin
          state_d = psi_pkg::ST_MUL;
        end else if (hit_equal || scan_last) begin
          state_d = psi_pkg::ST_FIN;
        end
      end
      psi_pkg::ST_MUL: begin
        state_d = psi_pkg::ST_DIV;
      end
      psi_pkg::ST_DIV: begin
        if (step_q == SW'(psi_pkg::DivSteps - 1)) begin
          state_d = psi_pkg::ST_ADJ;
        end
      end
      psi_pkg::ST_ADJ: begin
        state_d = psi_pkg::ST_FIN;
      end
      psi_pkg::ST_FIN: begin
        if (out_free) begin
          state_d = psi_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = psi_pkg::ST_IDLE;
      end
    endcase
  end

  // Output logic of the sequencer.
  always_comb begin
    in_ready_o = 1'b0;
    mem_we     = 1'b0;
    rd_addr    = idx_q + IdxW'(1);
    case (state_q)
      psi_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        mem_we     = in_valid_i && (in_data_i.action == psi_pkg::ACT_WRITE) && slot_ok;
        rd_addr    = '0;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= psi_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Control registers: point count, scan index, divide step, result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_count_q <= psi_pkg::PointCountReset;
      idx_q         <= '0;
      step_q        <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        point_count_q <= cfg_data_i;
      end
      if (state_q == psi_pkg::ST_IDLE) begin
        idx_q <= '0;
      end else if ((state_q == psi_pkg::ST_SCAN) && (state_d == psi_pkg::ST_SCAN)) begin
        idx_q <= idx_q + IdxW'(1);
      end
      if (state_q == psi_pkg::ST_DIV) begin
        step_q <= step_q + SW'(1);
      end else begin
        step_q <= '0;
      end
      if ((state_q == psi_pkg::ST_FIN) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Breakpoint memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_addr] <= '{pt_time: in_data_i.point_time, pt_temp: in_data_i.point_temperature};
    end
    rd_q <= mem_q[rd_addr];
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      psi_pkg::ST_IDLE: begin
        query_q     <= in_data_i.query_time;
        res_temp_q  <= '0;
        res_found_q <= 1'b0;
      end
      psi_pkg::ST_SCAN: begin
        prev_time_q <= rd_q.pt_time;
        prev_temp_q <= rd_q.pt_temp;
        if (hit_between) begin
          dt_q  <= query_q - prev_time_q;
          den_q <= rd_q.pt_time - prev_time_q;
          dv_q  <= $signed({1'b0, rd_q.pt_temp}) - $signed({1'b0, prev_temp_q});
          v0_q  <= prev_temp_q;
        end else if (hit_equal) begin
          res_temp_q  <= rd_q.pt_temp;
          res_found_q <= 1'b1;
        end
      end
      psi_pkg::ST_MUL: begin
        neg_q <= prod[TW+VW+1];
        quo_q <= prod_mag[QW-1:0];
        rem_q <= '0;
      end
      psi_pkg::ST_DIV: begin
        rem_q <= div_ge ? rem_diff[RW-1:0] : rem_shift;
        quo_q <= {quo_q[QW-2:0], div_ge};
      end
      psi_pkg::ST_ADJ: begin
        res_temp_q  <= lerp_temp;
        res_found_q <= 1'b1;
      end
      psi_pkg::ST_FIN: begin
        if (out_free) begin
          out_data_q <= '{target_temperature: res_temp_q, in_range: res_found_q};
        end
      end
      default: begin
        res_found_q <= res_found_q;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

### rtl/core/psi_sva.sv
// Port-level checker for the profile setpoint interpolator and its bind statement.
`timescale 1ns / 1ps

module psi_sva (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input psi_pkg::psi_in_t           in_data_i,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input psi_pkg::psi_out_t          out_data_o
);

  // A pending result stays offered until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before it was taken");

  // A stalled result keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("stalled result changed");

  // A result outside the table carries a zero temperature.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.in_range |-> out_data_o.target_temperature == '0)
    else $error("out-of-range result with nonzero temperature");

  // A query request keeps the block busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_data_i.action == psi_pkg::ACT_QUERY) |=> !in_ready_o)
    else $error("ready right after a query request");

  // A write request leaves the block ready in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_data_i.action == psi_pkg::ACT_WRITE) |=> in_ready_o)
    else $error("block busy after a write request");

endmodule

bind profile_setpoint_interpolator psi_sva u_psi_sva (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
